// ===== sv/console_attribute_to_sgr_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the console attribute to SGR encoder
// Concurrent assertion wrappers that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_ATTRIBUTE_TO_SGR_ENCODER_ASSERT_SVH
`define CONSOLE_ATTRIBUTE_TO_SGR_ENCODER_ASSERT_SVH

`ifndef SYNTH
// Checked property, switched off while reset is high.
`define CAS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sgr encoder assertion failed");
// Checked property that also holds during reset.
`define CAS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sgr encoder assertion failed");
`else
`define CAS_ASSERT(name, clk, rst, prop)
`define CAS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== sv/cas_pkg.sv =====
// ----------------------------------------------------------------------------
// Console attribute to SGR encoder package
// Shared constants, the queue entry type and the code descriptor function.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam logic [15:0] NONE_SENT       = 16'hFFFF;
  localparam logic [7:0]  DEFAULT_COLOURS = 8'h07;
  localparam logic [3:0]  DEFAULT_UNIT    = 4'd9;
  localparam logic [3:0]  HUNDREDS_DIGIT  = 4'd1;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_ZERO     = 8'h30;

  // Code slots in emission order.
  localparam int NUM_SLOTS      = 8;
  localparam int SLOT_BOLD_OFF  = 0;
  localparam int SLOT_UL_OFF    = 1;
  localparam int SLOT_REV_OFF   = 2;
  localparam int SLOT_BOLD_ON   = 3;
  localparam int SLOT_UL_ON     = 4;
  localparam int SLOT_REV_ON    = 5;
  localparam int SLOT_FG        = 6;
  localparam int SLOT_BG        = 7;

  // Queue depth; a power of two so that the pointers wrap naturally.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [3:0]           fg_unit;
    logic                 bg_bright;
    logic [3:0]           bg_unit;
  } entry_t;

  typedef struct packed {
    logic       has_hun;
    logic       has_ten;
    logic [3:0] ten;
    logic [3:0] unit;
  } code_desc_t;

  // Swap bits 0 and 2: BGR order to RGB order.
  function automatic logic [2:0] rgb_index(input logic [2:0] bgr);
    return {bgr[0], bgr[1], bgr[2]};
  endfunction

  // Decimal digits of the code in the slot marked by a one-hot vector.
  function automatic code_desc_t slot_desc(input logic [NUM_SLOTS-1:0] lowest,
                                           input entry_t e);
    code_desc_t d;
    d = '0;
    priority if (lowest[SLOT_BOLD_OFF]) begin
      d.has_ten = 1'b1; d.ten = 4'd2; d.unit = 4'd2;
    end else if (lowest[SLOT_UL_OFF]) begin
      d.has_ten = 1'b1; d.ten = 4'd2; d.unit = 4'd4;
    end else if (lowest[SLOT_REV_OFF]) begin
      d.has_ten = 1'b1; d.ten = 4'd2; d.unit = 4'd7;
    end else if (lowest[SLOT_BOLD_ON]) begin
      d.unit = 4'd1;
    end else if (lowest[SLOT_UL_ON]) begin
      d.unit = 4'd4;
    end else if (lowest[SLOT_REV_ON]) begin
      d.unit = 4'd7;
    end else if (lowest[SLOT_FG]) begin
      d.has_ten = 1'b1; d.ten = 4'd3; d.unit = e.fg_unit;
    end else if (lowest[SLOT_BG]) begin
      d.has_hun = e.bg_bright;
      d.has_ten = 1'b1;
      d.ten     = e.bg_bright ? 4'd0 : 4'd4;
      d.unit    = e.bg_unit;
    end else begin
      d = '0;
    end
    return d;
  endfunction

endpackage

// ===== sv/cas_attr_if.sv =====
// ----------------------------------------------------------------------------
// Attribute channel
// Valid/ready channel carrying one 16-bit console attribute per word.
// ----------------------------------------------------------------------------
interface cas_attr_if;
  logic        valid;
  logic        ready;
  logic [15:0] attribute;

  modport source (output valid, output attribute, input ready);
  modport sink   (input valid, input attribute, output ready);
endinterface

// ===== sv/cas_byte_if.sv =====
// ----------------------------------------------------------------------------
// SGR byte channel
// Valid/ready channel carrying one escape sequence byte per word.
// ----------------------------------------------------------------------------
interface cas_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== sv/cas_front.sv =====
// ----------------------------------------------------------------------------
// SGR encoder front end
// Compares each attribute with the stored one and queues the codes to send.
// ----------------------------------------------------------------------------
module cas_front import cas_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  cas_attr_if.sink attr_chan,
  output logic   push_valid,
  output entry_t push_entry,
  input  logic   push_ready
);

  logic [15:0] previous_attribute;
  logic        accept;
  logic [15:0] a;
  logic [15:0] p;
  logic        p_none, p_plain, p_bold, p_ul, p_rev;
  logic        c_plain, c_bold, c_ul, c_rev;
  logic        fg_chg, bg_chg;
  logic [NUM_SLOTS-1:0] mask;

  assign attr_chan.ready = push_ready;
  assign accept          = attr_chan.valid && push_ready;

  always_comb begin
    a = attr_chan.attribute;
    p = previous_attribute;

    // A stored all-ones value stands for a terminal in its default state.
    p_none  = (p == NONE_SENT);
    p_plain = p_none || (p[7:0] == DEFAULT_COLOURS);
    p_bold  = !p_plain && p[3];
    p_ul    = !p_none && p[15];
    p_rev   = !p_none && p[14];

    c_plain = (a[7:0] == DEFAULT_COLOURS);
    c_bold  = !c_plain && a[3];
    c_ul    = a[15];
    c_rev   = a[14];

    fg_chg = (c_plain != p_plain) || (!c_plain && (a[2:0] != p[2:0]));
    bg_chg = (c_plain != p_plain) || (!c_plain && (a[7:4] != p[7:4]));

    mask                = '0;
    mask[SLOT_BOLD_OFF] = p_bold && !c_bold;
    mask[SLOT_UL_OFF]   = p_ul && !c_ul;
    mask[SLOT_REV_OFF]  = p_rev && !c_rev;
    mask[SLOT_BOLD_ON]  = c_bold && !p_bold;
    mask[SLOT_UL_ON]    = c_ul && !p_ul;
    mask[SLOT_REV_ON]   = c_rev && !p_rev;
    mask[SLOT_FG]       = fg_chg;
    mask[SLOT_BG]       = bg_chg;

    push_entry.mask      = mask;
    push_entry.fg_unit   = c_plain ? DEFAULT_UNIT : {1'b0, rgb_index(a[2:0])};
    push_entry.bg_bright = !c_plain && a[7];
    push_entry.bg_unit   = c_plain ? DEFAULT_UNIT : {1'b0, rgb_index(a[6:4])};

    push_valid = accept && (a != p) && (mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_attribute <= NONE_SENT;
    end else if (accept) begin
      previous_attribute <= attr_chan.attribute;
    end
  end

endmodule

// ===== sv/cas_queue.sv =====
// ----------------------------------------------------------------------------
// SGR encoder command queue
// Short FIFO of code sets between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module cas_queue import cas_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   push_ready,
  output logic   pop_valid,
  output entry_t pop_entry,
  input  logic   pop_ready
);

  entry_t              store [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/cas_back.sv =====
// ----------------------------------------------------------------------------
// SGR encoder byte sequencer
// Turns a queued set into ESC '[' codes ';' ... 'm', a byte per ready cycle.
// ----------------------------------------------------------------------------
`include "console_attribute_to_sgr_encoder_assert.svh"

module cas_back import cas_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  input  entry_t pop_entry,
  output logic   pop_ready,
  cas_byte_if.source sgr_chan
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_BRACKET = 5'b00010,
    ST_DIGIT   = 5'b00100,
    ST_SEP     = 5'b01000,
    ST_MARK    = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    POS_HUN  = 2'd0,
    POS_TEN  = 2'd1,
    POS_UNIT = 2'd2
  } pos_t;

  state_t     state, state_next;
  entry_t     work, work_next;
  pos_t       pos, pos_next;
  logic       byte_valid, byte_valid_next;
  logic [7:0] byte_data, byte_data_next;
  logic       byte_last, byte_last_next;

  logic                 load;
  logic [NUM_SLOTS-1:0] lowest;
  logic [NUM_SLOTS-1:0] remaining;
  code_desc_t           desc;
  pos_t                 first_pos;
  logic [3:0]           digit;

  assign sgr_chan.valid     = byte_valid;
  assign sgr_chan.out_byte  = byte_data;
  assign sgr_chan.last_byte = byte_last;

  // The output register takes a new byte when empty or being taken.
  assign load = !byte_valid || sgr_chan.ready;

  always_comb begin
    lowest    = work.mask & (~work.mask + NUM_SLOTS'(1));
    remaining = work.mask & ~lowest;
    desc      = slot_desc(lowest, work);

    if (desc.has_hun) begin
      first_pos = POS_HUN;
    end else if (desc.has_ten) begin
      first_pos = POS_TEN;
    end else begin
      first_pos = POS_UNIT;
    end

    unique case (pos)
      POS_HUN: digit = HUNDREDS_DIGIT;
      POS_TEN: digit = desc.ten;
      default: digit = desc.unit;
    endcase
  end

  always_comb begin
    state_next      = state;
    work_next       = work;
    pos_next        = pos;
    byte_valid_next = byte_valid && !sgr_chan.ready;
    byte_data_next  = byte_data;
    byte_last_next  = byte_last;
    pop_ready       = 1'b0;

    if (load) begin
      unique case (state)
        ST_IDLE: begin
          pop_ready = 1'b1;
          if (pop_valid) begin
            work_next       = pop_entry;
            byte_valid_next = 1'b1;
            byte_data_next  = CH_ESC;
            byte_last_next  = 1'b0;
            state_next      = ST_BRACKET;
          end
        end
        ST_BRACKET: begin
          byte_valid_next = 1'b1;
          byte_data_next  = CH_LBRACKET;
          byte_last_next  = 1'b0;
          pos_next        = first_pos;
          state_next      = ST_DIGIT;
        end
        ST_DIGIT: begin
          byte_valid_next = 1'b1;
          byte_data_next  = CH_ZERO + {4'b0000, digit};
          byte_last_next  = 1'b0;
          if (pos == POS_UNIT) begin
            work_next.mask = remaining;
            state_next     = (remaining != '0) ? ST_SEP : ST_MARK;
          end else begin
            pos_next = (pos == POS_HUN) ? POS_TEN : POS_UNIT;
          end
        end
        ST_SEP: begin
          byte_valid_next = 1'b1;
          byte_data_next  = CH_SEMI;
          byte_last_next  = 1'b0;
          pos_next        = first_pos;
          state_next      = ST_DIGIT;
        end
        ST_MARK: begin
          byte_valid_next = 1'b1;
          byte_data_next  = CH_M;
          byte_last_next  = 1'b1;
          state_next      = ST_IDLE;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      byte_valid <= 1'b0;
    end else begin
      state      <= state_next;
      byte_valid <= byte_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    work      <= work_next;
    pos       <= pos_next;
    byte_data <= byte_data_next;
    byte_last <= byte_last_next;
  end

  `CAS_ASSERT(a_codes_left, clk, rst, (state == ST_BRACKET || state == ST_DIGIT || state == ST_SEP) |-> (work.mask != '0))
  `CAS_ASSERT(a_last_is_m, clk, rst, (sgr_chan.valid && sgr_chan.last_byte) |-> (sgr_chan.out_byte == CH_M))
  `CAS_ASSERT(a_mark_ends, clk, rst, (state == ST_MARK && load) |=> (state == ST_IDLE && sgr_chan.last_byte))
  `CAS_ASSERT(a_pop_starts, clk, rst, (pop_ready && pop_valid) |=> (state == ST_BRACKET && sgr_chan.out_byte == CH_ESC))
  `CAS_ASSERT_ALWAYS(a_pop_idle, clk, pop_ready |-> (state == ST_IDLE))

endmodule

// ===== sv/console_attribute_to_sgr_encoder.sv =====
// ----------------------------------------------------------------------------
// Console attribute to SGR encoder: an accepted word reaches ESC via the queue and
// the output register. A changed attribute gives 4 to 18 bytes, which the sequencer
// sends one a cycle while the receiver is ready. Unchanged or invisible attributes
// queue nothing; the front accepts every cycle while the two-entry queue has room.
// Reset (rst, synchronous): stored attribute 0xFFFF, queue empty, sequencer idle.
// ----------------------------------------------------------------------------
module console_attribute_to_sgr_encoder import cas_pkg::*; (
  input  logic clk,
  input  logic rst,
  cas_attr_if.sink   attr_chan,
  cas_byte_if.source sgr_chan
);

  // The front end holds the last attribute and decides, in the cycle a word
  // is accepted, which SGR codes the change needs. A word that changes
  // nothing visible still updates the stored attribute but queues nothing.
  logic   push_valid;
  entry_t push_entry;
  logic   push_ready;

  // The queue decouples the two halves: the front may take new attributes
  // while the sequencer is still spelling out an earlier escape, and it
  // stalls only when the queue is full.
  logic   pop_valid;
  entry_t pop_entry;
  logic   pop_ready;

  cas_front u_front (
    .clk        (clk),
    .rst        (rst),
    .attr_chan  (attr_chan),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  cas_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // The sequencer walks the code set lowest slot first, emitting one byte
  // into its output register each cycle the receiver does not stall. The
  // closing 'm' is followed directly by the ESC of the next queued
  // sequence, so back-to-back escapes leave no gap on the byte channel.
  cas_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .sgr_chan  (sgr_chan)
  );

endmodule

// ===== tb/tb_console_attribute_to_sgr_encoder.sv =====
// ----------------------------------------------------------------------------
// Testbench for the console attribute to SGR encoder
// Feeds console attribute words through the attribute channel, predicts the
// escape sequence bytes that each accepted word should produce and checks
// every byte on the SGR channel against that prediction. The run walks
// through a directed set, random phases with different amounts of idling on
// either side, and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_console_attribute_to_sgr_encoder;
  import cas_pkg::*;

  // Generous cycle budget; the slowest legal run needs a small part of this.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles allowed after the last expected byte for the block to settle.
  localparam int SETTLE_TICKS = 24;
  localparam int PHASE_WORDS  = 68;
  localparam int SQUEEZE_WORDS = 20;
  localparam int SQUEEZE_HOLD  = 300;

  // Rendering state of an attribute as a terminal would see it. A colour of
  // -1 stands for the terminal default.
  typedef struct {
    int fg;
    int bg;
    bit bold;
    bit underline;
    bit reverse;
  } look_t;

  // One byte of an escape sequence as the block should send it.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       closing;
  } sgr_word_t;

  logic clk = 1'b0;
  logic rst;

  cas_attr_if attr_chan ();
  cas_byte_if sgr_chan ();

  console_attribute_to_sgr_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .attr_chan (attr_chan),
    .sgr_chan  (sgr_chan)
  );

  always #2 clk = ~clk;

  // Words waiting to be offered, oldest first; the driver always offers the
  // front one and the sampling block removes it once the block has taken it.
  logic [15:0] pending_attrs[$];
  // Bytes the block still owes us, oldest first.
  sgr_word_t   owed_bytes[$];

  // Shadow of the attribute the block has stored; it leaves reset as
  // "nothing sent yet".
  logic [15:0] shadow_attr = NONE_SENT;

  // Scratch area in which one escape sequence is assembled.
  logic [7:0]  staged[$];
  int          staged_codes;

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  // The stimulus process asks for a hold-off by bumping the ticket; the
  // receiver counts the cycles itself.
  int hold_ticket = 0;
  int hold_length = 0;
  int hold_served = 0;
  int hold_left   = 0;

  bit took_word = 1'b0;
  int words_taken = 0;
  int bytes_checked = 0;
  int sequences_seen = 0;
  int failures = 0;
  int cycle_count = 0;

  // Colour index: the three colour bits come in blue, green, red order and
  // the terminal wants red, green, blue.
  function automatic int rgb_of(input logic [2:0] bgr);
    return int'(bgr[0]) * 4 + int'(bgr[1]) * 2 + int'(bgr[2]);
  endfunction

  function automatic look_t look_of(input logic [15:0] a);
    look_t s;
    s.underline = a[15];
    s.reverse   = a[14];
    if (a[7:0] == DEFAULT_COLOURS) begin
      // The default colour pair also means plain weight.
      s.fg   = -1;
      s.bg   = -1;
      s.bold = 1'b0;
    end else begin
      s.fg   = 30 + rgb_of(a[2:0]);
      s.bg   = (a[7] ? 100 : 40) + rgb_of(a[6:4]);
      s.bold = a[3];
    end
    return s;
  endfunction

  // Adds one decimal code to the sequence being assembled, with a separator
  // in front of every code but the first.
  task automatic append_code(input int code);
    if (staged_codes != 0) staged.push_back(CH_SEMI);
    staged_codes++;
    if (code >= 100) staged.push_back(CH_ZERO + 8'(code / 100));
    if (code >= 10) staged.push_back(CH_ZERO + 8'((code / 10) % 10));
    staged.push_back(CH_ZERO + 8'(code % 10));
  endtask

  // Works out the bytes that an accepted attribute word causes and queues
  // them as owed.
  task automatic predict_sequence(input logic [15:0] incoming);
    look_t was_shown;
    look_t now_shown;
    sgr_word_t w;
    if (incoming == shadow_attr) return;
    if (shadow_attr == NONE_SENT) begin
      // Nothing has been sent yet, so the terminal is in its default state.
      was_shown.fg = -1;
      was_shown.bg = -1;
      was_shown.bold = 1'b0;
      was_shown.underline = 1'b0;
      was_shown.reverse = 1'b0;
    end else begin
      was_shown = look_of(shadow_attr);
    end
    shadow_attr = incoming;
    now_shown = look_of(incoming);

    staged.delete();
    staged_codes = 0;
    staged.push_back(CH_ESC);
    staged.push_back(CH_LBRACKET);
    if (was_shown.bold && !now_shown.bold) append_code(22);
    if (was_shown.underline && !now_shown.underline) append_code(24);
    if (was_shown.reverse && !now_shown.reverse) append_code(27);
    if (now_shown.bold && !was_shown.bold) append_code(1);
    if (now_shown.underline && !was_shown.underline) append_code(4);
    if (now_shown.reverse && !was_shown.reverse) append_code(7);
    if (now_shown.fg != was_shown.fg) append_code(now_shown.fg >= 0 ? now_shown.fg : 39);
    if (now_shown.bg != was_shown.bg) append_code(now_shown.bg >= 0 ? now_shown.bg : 49);
    // A change that nobody could see produces no bytes at all.
    if (staged_codes == 0) return;
    staged.push_back(CH_M);
    sequences_seen++;
    foreach (staged[i]) begin
      w.code_byte = staged[i];
      w.closing   = (i == staged.size() - 1);
      owed_bytes.push_back(w);
    end
  endtask

  // Picks the next random attribute. Plenty of repeats, default colours,
  // all-ones words and single-bit changes are mixed in, since those reach the
  // quiet cases and the one-code sequences; the rest is fully random.
  function automatic logic [15:0] pick_attr(input logic [15:0] last_attr);
    int roll;
    logic [15:0] a;
    roll = $urandom_range(99);
    a = 16'($urandom);
    if (roll < 15) begin
      a = last_attr;
    end else if (roll < 27) begin
      a[7:0] = DEFAULT_COLOURS;
    end else if (roll < 32) begin
      a = NONE_SENT;
    end else if (roll < 50) begin
      a = last_attr ^ (16'h0001 << $urandom_range(15));
    end
    return a;
  endfunction

  // Sender: presents the front pending word at the falling edge and keeps
  // it steady until the block has taken it.
  always @(negedge clk) begin
    if (rst) begin
      attr_chan.valid     <= 1'b0;
      attr_chan.attribute <= 16'h0000;
    end else if (attr_chan.valid && !took_word) begin
      // The word on offer has not been taken yet: leave it as it is.
    end else if (pending_attrs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      attr_chan.valid     <= 1'b1;
      attr_chan.attribute <= pending_attrs[0];
    end else begin
      attr_chan.valid     <= 1'b0;
      attr_chan.attribute <= 16'($urandom);
    end
  end

  // Receiver: stalls at random, or for a whole hold-off when asked to.
  always @(negedge clk) begin
    if (rst) begin
      sgr_chan.ready <= 1'b0;
    end else if (hold_served != hold_ticket) begin
      hold_served    <= hold_ticket;
      hold_left      <= hold_length;
      sgr_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      sgr_chan.ready <= 1'b0;
    end else begin
      sgr_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Both handshakes are sampled at the rising edge. A word taken on the
  // attribute side feeds the predictor; a byte taken on the SGR side is
  // checked against the oldest owed byte.
  always @(posedge clk) begin
    sgr_word_t want;
    took_word <= attr_chan.valid && attr_chan.ready;
    if (!rst && attr_chan.valid && attr_chan.ready) begin
      void'(pending_attrs.pop_front());
      predict_sequence(attr_chan.attribute);
      words_taken++;
    end
    if (!rst && sgr_chan.valid && sgr_chan.ready) begin
      if (owed_bytes.size() == 0) begin
        $error("unexpected byte %h (last_byte %b) with nothing owed",
               sgr_chan.out_byte, sgr_chan.last_byte);
        failures++;
      end else begin
        want = owed_bytes.pop_front();
        if (sgr_chan.out_byte !== want.code_byte) begin
          $error("out_byte: expected %h, actual %h", want.code_byte, sgr_chan.out_byte);
          failures++;
        end
        if (sgr_chan.last_byte !== want.closing) begin
          $error("last_byte: expected %b, actual %b", want.closing, sgr_chan.last_byte);
          failures++;
        end
        bytes_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("console_attribute_to_sgr_encoder test failed");
      $finish;
    end
  end

  // Waits until every pending word has been taken and every owed byte has
  // arrived, then lets the block settle so that it finishes any quiet words.
  task automatic wait_for_drain();
    while (pending_attrs.size() > 0 || owed_bytes.size() > 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  initial begin
    logic [15:0] directed[$];
    logic [15:0] last_attr;
    int idle_set[4];
    int stall_set[4];

    rst = 1'b1;
    attr_chan.valid     = 1'b0;
    attr_chan.attribute = 16'h0000;
    sgr_chan.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words, in order:
    //   default colours straight after reset (no visible change), the same
    //   again (unchanged), every "on" code with black colours, the longest
    //   sequence, single colours checking the blue/red swap, back to the
    //   default colours, a change in the ignored bits only, the all-ones
    //   word and its repeat, default colours after it (nothing to say),
    //   underline from the all-ones state, reverse with black, the bright
    //   background, full white, all zeros, the ignored bits with colours,
    //   underline and reverse off, a plain background and default again.
    directed = '{16'h0007, 16'h0007, 16'hC008, 16'h00F7, 16'h0001, 16'h0004,
                 16'h0002, 16'h3F07, 16'h0007, 16'hFFFF, 16'hFFFF, 16'h0007,
                 16'hFFFF, 16'h8007, 16'h4000, 16'h0080, 16'h00FF, 16'h0000,
                 16'hFF00, 16'h3F00, 16'h0070, 16'h0007};
    foreach (directed[i]) pending_attrs.push_back(directed[i]);
    last_attr = directed[directed.size() - 1];
    wait_for_drain();

    // Random phases: no idling, sender idling half the time, receiver
    // stalling half the time, and both idling now and then.
    idle_set  = '{0, 50, 0, 12};
    stall_set = '{0, 0, 50, 12};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_set[p];
      receiver_stall_pct = stall_set[p];
      for (int k = 0; k < PHASE_WORDS; k++) begin
        last_attr = pick_attr(last_attr);
        pending_attrs.push_back(last_attr);
      end
      // The sender runs dry here and pauses until every owed byte is in.
      wait_for_drain();
    end

    // Squeeze: the receiver holds off for a long stretch while the sender
    // keeps offering changing words, so the block fills up and stops
    // taking words until the receiver comes back.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    for (int k = 0; k < SQUEEZE_WORDS; k++) begin
      last_attr = ~last_attr ^ 16'($urandom_range(255));
      pending_attrs.push_back(last_attr);
    end
    hold_length = SQUEEZE_HOLD;
    hold_ticket++;
    wait_for_drain();

    $display("Covered %0d attribute words giving %0d escape sequences (%0d bytes checked).",
             words_taken, sequences_seen, bytes_checked);
    $display("Phases: directed, free flow, sender idling, receiver stalling, both, squeeze.");
    if (failures == 0 && owed_bytes.size() == 0) begin
      $display("console_attribute_to_sgr_encoder test passed");
    end else begin
      $display("console_attribute_to_sgr_encoder test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cas_pkg.sv
sv/cas_attr_if.sv
sv/cas_byte_if.sv
sv/cas_front.sv
sv/cas_queue.sv
sv/cas_back.sv
sv/console_attribute_to_sgr_encoder.sv
tb/tb_console_attribute_to_sgr_encoder.sv
